// ----- hdl/lobm_pkg.sv -----
// Shared constants for the limit order book matcher: default sizes,
// field widths, event and status codes, register indexes. No dependencies.
`default_nettype none
package lobm_pkg;
	localparam int LEVELS_DEF    = 512;
	localparam int SLOTS_DEF     = 16;
	localparam int SIZE_BITS_DEF = 16;

	localparam int LEVEL_W = 9;
	localparam int QTY_W   = 16;
	localparam int POS_W   = 4;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MARKET = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOCANC = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

	localparam logic REG_MIN_LEVEL = 1'b0;
	localparam logic REG_MAX_LEVEL = 1'b1;

	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 9'd0;
	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 9'd511;
endpackage
`default_nettype wire

// ----- hdl/limit_order_book_matcher_core.sv -----
// Limit order book matcher top level: event sequencer around the level-count
// and order-size memories. Depends on lobm_pkg and lobm_ram.
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall  | mode side level quantity queue_position
// out     | output    | out_valid / out_stall| status best_bid best_ask last_level trade_side
// cfg     | input     | cfg_write            | cfg_index cfg_data
//
// Each event runs on a sequencer over the two memories, one read a cycle each.
// Add reads the level count and writes the entry and the new count. Cancel reads the
// count, shifts later entries down, writes the count and may walk levels for a new
// best. Market walks to a filled level, then reads, dequeues or reduces front orders,
// shifting entries and walking on. After reset a clearing pass zeroes every entry of
// the level-count memory; no transaction is taken on meanwhile. A result waits
// in the output register, and the next event runs while out_stall holds it.
`default_nettype none
module limit_order_book_matcher_core
	import lobm_pkg::*;
#(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int SLOTS     = SLOTS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic               side,
	input  wire logic [LEVEL_W-1:0] level,
	input  wire logic [QTY_W-1:0]   quantity,
	input  wire logic [POS_W-1:0]   queue_position,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [STAT_W-1:0]       status,
	output logic [LEVEL_W-1:0]      best_bid,
	output logic [LEVEL_W-1:0]      best_ask,
	output logic [LEVEL_W-1:0]      last_level,
	output logic                    trade_side,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [LEVEL_W-1:0] cfg_data
);
	localparam int LW = $clog2(LEVELS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int AW = $clog2(LEVELS * SLOTS);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ADD, S_CAN, S_SHR, S_SHW, S_CNT,
		S_SKRD, S_SKCK, S_MKRD, S_MKCK, S_FIN
	} state_t;

	typedef enum logic [1:0] {
		CTX_CAN_ASK, CTX_CAN_BID, CTX_MKT_FIND, CTX_MKT_AFTER
	} ctx_t;

	state_t              state_q;
	ctx_t                ctx_q;
	logic [LW-1:0]       clr_q, p_q, best_bid_q, best_ask_q, last_lvl_q;
	logic                trd_side_q, side_q, dir_up_q, out_valid_q;
	logic [LEVEL_W-1:0]  lv_q, min_q, max_q;
	logic [MODE_W-1:0]   mode_q;
	logic [QTY_W-1:0]    rem_q;
	logic [POS_W-1:0]    pos_q;
	logic [CW-1:0]       cnt_q, k_q;
	logic [STAT_W-1:0]   status_q, out_status_q;
	logic [LEVEL_W-1:0]  out_bid_q, out_ask_q, out_last_q;
	logic                out_side_q;

	logic                cnt_we, sz_we;
	logic [LW-1:0]       cnt_waddr, cnt_raddr;
	logic [CW-1:0]       cnt_wdata, cnt_rd;
	logic [AW-1:0]       sz_waddr, sz_raddr, base;
	logic [SIZE_BITS-1:0] sz_wdata, sz_rd;
	logic [LW:0]         nxt_w;
	logic                walk_ok, accept, add_ok, front_le, out_load;

	lobm_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rd)
	);

	lobm_ram #(.WIDTH(SIZE_BITS), .DEPTH(LEVELS * SLOTS)) u_sz_ram (
		.clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
		.raddr(sz_raddr), .rdata(sz_rd)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign base     = AW'(p_q) * AW'(SLOTS);
	assign nxt_w    = dir_up_q ? ({1'b0, p_q} + (LW+1)'(1)) : ({1'b0, p_q} - (LW+1)'(1));
	assign walk_ok  = (dir_up_q ? (32'(nxt_w) < 32'(LEVELS)) : (p_q != '0))
		&& (32'(nxt_w) >= 32'(min_q)) && (32'(nxt_w) <= 32'(max_q));
	assign add_ok   = 32'(cnt_rd) < 32'(SLOTS);
	assign front_le = 32'(sz_rd) <= 32'(rem_q);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = p_q;
		cnt_wdata = cnt_q - CW'(1);
		cnt_raddr = p_q;
		sz_we     = 1'b0;
		sz_waddr  = base;
		sz_wdata  = SIZE_BITS'(rem_q);
		sz_raddr  = base;
		case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
			end
			S_IDLE: cnt_raddr = LW'(level);
			S_ADD: begin
				cnt_we    = add_ok;
				cnt_wdata = cnt_rd + CW'(1);
				sz_we     = add_ok;
				sz_waddr  = base + AW'(cnt_rd);
			end
			S_SHR: sz_raddr = base + AW'(k_q);
			S_SHW: begin
				sz_we    = 1'b1;
				sz_waddr = base + AW'(k_q) - AW'(1);
				sz_wdata = sz_rd;
			end
			S_CNT: cnt_we = 1'b1;
			S_MKCK: begin
				sz_we    = !front_le;
				sz_wdata = SIZE_BITS'(32'(sz_rd) - 32'(rem_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ctx_q        <= CTX_MKT_FIND;
			clr_q        <= '0;
			p_q          <= '0;
			best_bid_q   <= LW'(LEVELS / 2 - 1);
			best_ask_q   <= LW'(LEVELS / 2 + 1);
			last_lvl_q   <= LW'(LEVELS / 2);
			trd_side_q   <= 1'b0;
			side_q       <= 1'b0;
			dir_up_q     <= 1'b0;
			lv_q         <= '0;
			min_q        <= MIN_LEVEL_RST;
			max_q        <= MAX_LEVEL_RST;
			mode_q       <= MODE_ADD;
			rem_q        <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_bid_q    <= '0;
			out_ask_q    <= '0;
			out_last_q   <= '0;
			out_side_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_MIN_LEVEL) begin
					min_q <= cfg_data;
				end else begin
					max_q <= cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= status_q;
				out_bid_q    <= LEVEL_W'(best_bid_q);
				out_ask_q    <= LEVEL_W'(best_ask_q);
				out_last_q   <= LEVEL_W'(last_lvl_q);
				out_side_q   <= trd_side_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + LW'(1);
					if (32'(clr_q) == 32'(LEVELS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q   <= mode;
						side_q   <= side;
						lv_q     <= level;
						rem_q    <= quantity;
						pos_q    <= queue_position;
						status_q <= ST_OK;
						dir_up_q <= side;
						ctx_q    <= CTX_MKT_FIND;
						p_q      <= LW'(level);
						unique case (mode)
							MODE_ADD: begin
								if (32'(level) < 32'(LEVELS)) begin
									state_q <= S_ADD;
								end else begin
									status_q <= ST_RANGE;
									state_q  <= S_FIN;
								end
							end
							MODE_CANCEL: begin
								if (32'(level) < 32'(LEVELS)) begin
									state_q <= S_CAN;
								end else begin
									status_q <= ST_NOCANC;
									state_q  <= S_FIN;
								end
							end
							MODE_MARKET: begin
								p_q     <= side ? best_ask_q : best_bid_q;
								state_q <= (quantity == '0) ? S_FIN : S_SKRD;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_ADD: begin
					if (!add_ok) begin
						status_q <= ST_FULL;
					end else begin
						if (!side_q && p_q > best_bid_q) begin
							best_bid_q <= p_q;
						end
						if (side_q && p_q < best_ask_q) begin
							best_ask_q <= p_q;
						end
					end
					state_q <= S_FIN;
				end
				S_CAN: begin
					cnt_q <= cnt_rd;
					if (32'(pos_q) >= 32'(cnt_rd)) begin
						status_q <= ST_NOCANC;
						state_q  <= S_FIN;
					end else begin
						k_q     <= CW'(pos_q) + CW'(1);
						state_q <= ((CW'(pos_q) + CW'(1)) < cnt_rd) ? S_SHR : S_CNT;
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					k_q     <= k_q + CW'(1);
					state_q <= ((k_q + CW'(1)) < cnt_q) ? S_SHR : S_CNT;
				end
				S_CNT: begin
					if (mode_q == MODE_CANCEL) begin
						if (cnt_q == CW'(1) && LW'(lv_q) == best_ask_q) begin
							dir_up_q <= 1'b1;
							ctx_q    <= CTX_CAN_ASK;
							state_q  <= S_SKRD;
						end else if (cnt_q == CW'(1) && LW'(lv_q) == best_bid_q) begin
							dir_up_q <= 1'b0;
							ctx_q    <= CTX_CAN_BID;
							state_q  <= S_SKRD;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						if (rem_q == '0) begin
							last_lvl_q <= p_q;
							trd_side_q <= side_q;
							ctx_q      <= CTX_MKT_AFTER;
						end else begin
							ctx_q <= CTX_MKT_FIND;
						end
						state_q <= S_SKRD;
					end
				end
				S_SKRD: state_q <= S_SKCK;
				S_SKCK: begin
					cnt_q <= cnt_rd;
					if (cnt_rd == '0 && walk_ok) begin
						p_q     <= nxt_w[LW-1:0];
						state_q <= S_SKRD;
					end else begin
						if (cnt_rd == '0) begin
							status_q <= ST_RANGE;
						end
						case (ctx_q)
							CTX_CAN_ASK: begin
								if (cnt_rd != '0) begin
									best_ask_q <= p_q;
								end
								if (LW'(lv_q) == best_bid_q) begin
									p_q      <= LW'(lv_q);
									dir_up_q <= 1'b0;
									ctx_q    <= CTX_CAN_BID;
									state_q  <= S_SKRD;
								end else begin
									state_q <= S_FIN;
								end
							end
							CTX_CAN_BID: begin
								if (cnt_rd != '0) begin
									best_bid_q <= p_q;
								end
								state_q <= S_FIN;
							end
							CTX_MKT_FIND: state_q <= (cnt_rd != '0) ? S_MKRD : S_FIN;
							default: begin
								if (cnt_rd != '0) begin
									if (side_q) begin
										best_ask_q <= p_q;
									end else begin
										best_bid_q <= p_q;
									end
								end
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_MKRD: state_q <= S_MKCK;
				S_MKCK: begin
					if (front_le) begin
						rem_q   <= QTY_W'(32'(rem_q) - 32'(sz_rd));
						k_q     <= CW'(1);
						state_q <= (CW'(1) < cnt_q) ? S_SHR : S_CNT;
					end else begin
						rem_q      <= '0;
						last_lvl_q <= p_q;
						trd_side_q <= side_q;
						if (side_q) begin
							best_ask_q <= p_q;
						end else begin
							best_bid_q <= p_q;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign best_bid   = out_bid_q;
	assign best_ask   = out_ask_q;
	assign last_level = out_last_q;
	assign trade_side = out_side_q;

`ifndef NO_ASSERTIONS
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish");
	a_no_sz_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !sz_we)
		else $error("size write during clearing pass");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (32'(cnt_wdata) <= 32'(SLOTS)))
		else $error("level count beyond queue depth");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (32'(p_q) < 32'(LEVELS)))
		else $error("walk pointer left the book");
	a_shift_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHW) |-> (k_q < cnt_q))
		else $error("shift beyond queue fill");
`endif
endmodule
`default_nettype wire

// ----- hdl/lobm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lobm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sim/limit_order_book_matcher_core_checker.sv -----
// Checker for limit_order_book_matcher_core: watches the event, result and register ports,
// keeps its own copy of the book, predicts every result and compares it. Depends on lobm_pkg.
`timescale 1ns / 100ps
`default_nettype none
module limit_order_book_matcher_core_checker
	import lobm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic               side,
	input  wire logic [LEVEL_W-1:0] level,
	input  wire logic [QTY_W-1:0]   quantity,
	input  wire logic [POS_W-1:0]   queue_position,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [STAT_W-1:0]  status,
	input  wire logic [LEVEL_W-1:0] best_bid,
	input  wire logic [LEVEL_W-1:0] best_ask,
	input  wire logic [LEVEL_W-1:0] last_level,
	input  wire logic               trade_side,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [LEVEL_W-1:0] cfg_data,
	output int                      errors,
	output int                      pending
);
	localparam int NLEV = LEVELS_DEF;
	localparam int NSLOT = SLOTS_DEF;

	typedef struct packed {
		logic [STAT_W-1:0]  st;
		logic [LEVEL_W-1:0] bid;
		logic [LEVEL_W-1:0] ask;
		logic [LEVEL_W-1:0] trade_lv;
		logic               trade_sd;
	} book_view_t;

	book_view_t book_view_q[$];
	int errs;

	logic [4:0]         depth_at [NLEV];
	logic [QTY_W-1:0]   size_at  [NLEV][NSLOT];
	logic [LEVEL_W-1:0] bid_lv, ask_lv, trade_lv, lo_lim, hi_lim;
	logic               trade_sd;

	function automatic bit seek_level(inout int p, input int dir);
		while (depth_at[p] == 0) begin
			p += dir;
			if (p < 0 || p >= NLEV || p < int'(lo_lim) || p > int'(hi_lim))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void drop_entry(input int lv, input int pos);
		int n;
		n = depth_at[lv];
		for (int i = pos; i + 1 < n; i++)
			size_at[lv][i] = size_at[lv][i + 1];
		depth_at[lv] = 5'(n - 1);
	endfunction

	function automatic book_view_t match_event(input logic [MODE_W-1:0] md, input logic sd,
			input int lv, input int qty, input int pos);
		book_view_t r;
		int p, dir, rem, front;
		r.st = ST_OK;
		if (md == MODE_ADD) begin
			if (depth_at[lv] >= NSLOT) begin
				r.st = ST_FULL;
			end else begin
				size_at[lv][depth_at[lv]] = QTY_W'(qty);
				depth_at[lv] = depth_at[lv] + 5'd1;
				if (!sd && lv > int'(bid_lv))
					bid_lv = LEVEL_W'(lv);
				if (sd && lv < int'(ask_lv))
					ask_lv = LEVEL_W'(lv);
			end
		end else if (md == MODE_CANCEL) begin
			if (pos >= int'(depth_at[lv])) begin
				r.st = ST_NOCANC;
			end else begin
				drop_entry(lv, pos);
				if (depth_at[lv] == 0) begin
					if (lv == int'(ask_lv)) begin
						p = lv;
						if (seek_level(p, 1))
							ask_lv = LEVEL_W'(p);
						else
							r.st = ST_RANGE;
					end
					if (lv == int'(bid_lv)) begin
						p = lv;
						if (seek_level(p, -1))
							bid_lv = LEVEL_W'(p);
						else
							r.st = ST_RANGE;
					end
				end
			end
		end else if (md == MODE_MARKET) begin
			dir = sd ? 1 : -1;
			p = sd ? int'(ask_lv) : int'(bid_lv);
			rem = qty;
			while (rem > 0) begin
				if (!seek_level(p, dir)) begin
					r.st = ST_RANGE;
					break;
				end
				front = size_at[p][0];
				if (front <= rem) begin
					drop_entry(p, 0);
					rem -= front;
					if (rem == 0) begin
						trade_lv = LEVEL_W'(p);
						trade_sd = sd;
						if (seek_level(p, dir)) begin
							if (sd)
								ask_lv = LEVEL_W'(p);
							else
								bid_lv = LEVEL_W'(p);
						end else begin
							r.st = ST_RANGE;
						end
					end
				end else begin
					size_at[p][0] = QTY_W'(front - rem);
					rem = 0;
					trade_lv = LEVEL_W'(p);
					trade_sd = sd;
					if (sd)
						ask_lv = LEVEL_W'(p);
					else
						bid_lv = LEVEL_W'(p);
				end
			end
		end
		r.bid = bid_lv;
		r.ask = ask_lv;
		r.trade_lv = trade_lv;
		r.trade_sd = trade_sd;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		book_view_t want;
		if (!arst_n) begin
			for (int i = 0; i < NLEV; i++)
				depth_at[i] = '0;
			bid_lv = LEVEL_W'(NLEV / 2 - 1);
			ask_lv = LEVEL_W'(NLEV / 2 + 1);
			trade_lv = LEVEL_W'(NLEV / 2);
			trade_sd = 1'b0;
			lo_lim = MIN_LEVEL_RST;
			hi_lim = MAX_LEVEL_RST;
			book_view_q.delete();
			errs = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_MIN_LEVEL)
					lo_lim = cfg_data;
				else
					hi_lim = cfg_data;
			end
			if (in_valid && !in_stall)
				book_view_q.insert(book_view_q.size(), match_event(mode, side, int'(level),
					int'(quantity), int'(queue_position)));
			if (out_valid && !out_stall) begin
				if (book_view_q.size() == 0) begin
					$display("%0t: result with no transaction waiting", $time);
					errs++;
				end else begin
					want = book_view_q.pop_front();
					if (status !== want.st) begin
						$display("%0t: status exp %0d got %0d", $time, want.st, status);
						errs++;
					end
					if (best_bid !== want.bid) begin
						$display("%0t: best_bid exp %0d got %0d", $time, want.bid, best_bid);
						errs++;
					end
					if (best_ask !== want.ask) begin
						$display("%0t: best_ask exp %0d got %0d", $time, want.ask, best_ask);
						errs++;
					end
					if (last_level !== want.trade_lv) begin
						$display("%0t: last_level exp %0d got %0d", $time, want.trade_lv,
							last_level);
						errs++;
					end
					if (trade_side !== want.trade_sd) begin
						$display("%0t: trade_side exp %0d got %0d", $time, want.trade_sd,
							trade_side);
						errs++;
					end
				end
			end
			errors <= errs;
			pending <= book_view_q.size();
		end
	end
endmodule
`default_nettype wire

// ----- sim/limit_order_book_matcher_core_test.sv -----
// Testbench top for limit_order_book_matcher_core: reset, register phases, directed and
// random order events with bursty sender and stalling receiver. Depends on lobm_pkg, checker.
`timescale 1ns / 100ps
`default_nettype none
module limit_order_book_matcher_core_test;
	import lobm_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int PHASE_EVENTS = 205;

	logic               clk, arst_n;
	logic               in_valid, in_stall, out_valid, out_stall;
	logic [MODE_W-1:0]  mode;
	logic               side;
	logic [LEVEL_W-1:0] level;
	logic [QTY_W-1:0]   quantity;
	logic [POS_W-1:0]   queue_position;
	logic [STAT_W-1:0]  status;
	logic [LEVEL_W-1:0] best_bid, best_ask, last_level;
	logic               trade_side;
	logic               cfg_write, cfg_index;
	logic [LEVEL_W-1:0] cfg_data;
	int                 errors, pending;
	int                 burst_left, idle_cycles;
	bit                 hold_req;

	limit_order_book_matcher_core dut (.*);
	limit_order_book_matcher_core_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int pct;
		out_stall = 1'b0;
		pct = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0)
					case ($urandom_range(0, 3))
						0: pct = 0;
						1: pct = 25;
						2: pct = 50;
						default: pct = 90;
					endcase
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("limit_order_book_matcher_core_test failed");
			$finish;
		end
	end

	task automatic send_event(input logic [MODE_W-1:0] md, input logic sd,
			input int lv, input int qty, input int pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= md;
		side <= sd;
		level <= LEVEL_W'(lv);
		quantity <= QTY_W'(qty);
		queue_position <= POS_W'(pos);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_limits(input int lo, input int hi);
		cfg_write <= 1'b1;
		cfg_index <= REG_MIN_LEVEL;
		cfg_data <= LEVEL_W'(lo);
		@(posedge clk);
		cfg_index <= REG_MAX_LEVEL;
		cfg_data <= LEVEL_W'(hi);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_event();
		int md, lv, qty, pos, r;
		r = $urandom_range(0, 99);
		md = (r < 42) ? MODE_ADD : (r < 65) ? MODE_CANCEL : (r < 96) ? MODE_MARKET :
			MODE_UNUSED;
		r = $urandom_range(0, 9);
		lv = (r < 8) ? $urandom_range(244, 268) : $urandom_range(0, 511);
		if (md == MODE_MARKET) begin
			r = $urandom_range(0, 9);
			qty = (r < 6) ? $urandom_range(1, 60) : (r < 9) ? $urandom_range(1, 300) :
				$urandom_range(0, 65535);
		end else begin
			r = $urandom_range(0, 19);
			qty = (r < 15) ? $urandom_range(1, 40) : (r == 15) ? 0 : $urandom_range(0, 65535);
		end
		pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
		send_event(MODE_W'(md), 1'($urandom_range(0, 1)), lv, qty, pos);
	endtask

	initial begin
		int lo_set[6] = '{0, 240, 256, 511, 100, 0};
		int hi_set[6] = '{511, 272, 256, 0, 400, 511};
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ADD;
		side = 1'b0;
		level = '0;
		quantity = '0;
		queue_position = '0;
		cfg_write = 1'b0;
		cfg_index = REG_MIN_LEVEL;
		cfg_data = '0;
		hold_req = 1'b0;
		burst_left = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full queue, zero and max sizes, edge levels, empty cancel, unused mode
		for (int i = 0; i < 17; i++)
			send_event(MODE_ADD, 1'b0, 250, (i == 0) ? 0 : (i == 1) ? 65535 : i, 0);
		send_event(MODE_CANCEL, 1'b0, 250, 0, 15);
		send_event(MODE_CANCEL, 1'b1, 511, 0, 0);
		send_event(MODE_ADD, 1'b1, 511, 7, 0);
		send_event(MODE_ADD, 1'b0, 0, 3, 0);
		send_event(MODE_UNUSED, 1'b1, 511, 65535, 15);
		send_event(MODE_MARKET, 1'b1, 0, 0, 0);
		send_event(MODE_MARKET, 1'b0, 0, 65535, 0);
		send_event(MODE_MARKET, 1'b1, 0, 65535, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			set_limits(lo_set[ph], hi_set[ph]);
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				if (ph == 1 && n == 60)
					hold_req = 1'b1;
				if (ph == 4 && n == 100)
					drain();
				random_event();
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("limit_order_book_matcher_core_test passed");
		else
			$display("limit_order_book_matcher_core_test failed");
		$finish;
	end
endmodule
`default_nettype wire
